### rtl/ibpe_pkg.sv
package ibpe_pkg;

  localparam int DEF_MAX_ROWS = 512;
  localparam int DEF_MAX_COLS = 512;
  localparam int DEF_MAX_PAD  = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_PAD_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_SIZE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE   = 3'd4;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [2:0] PAD_CONSTANT  = 3'd0;
  localparam logic [2:0] PAD_EDGE      = 3'd1;
  localparam logic [2:0] PAD_REFLECT   = 3'd2;
  localparam logic [2:0] PAD_SYMMETRIC = 3'd3;
  localparam logic [2:0] PAD_MAXIMUM   = 3'd4;
  localparam logic [2:0] PAD_MINIMUM   = 3'd5;
  localparam logic [2:0] PAD_MEAN      = 3'd6;

  // Source of a read result.
  localparam logic [2:0] SRC_IMAGE = 3'd0;
  localparam logic [2:0] SRC_COL   = 3'd1;
  localparam logic [2:0] SRC_ROW   = 3'd2;
  localparam logic [2:0] SRC_ALL   = 3'd3;
  localparam logic [2:0] SRC_FILL  = 3'd4;
  localparam logic [2:0] SRC_ZERO  = 3'd5;

  localparam int COL_SUM_W = 17;
  localparam int IMG_SUM_W = 26;
  localparam int STAT_W    = 8 + 8 + COL_SUM_W;
  localparam int MEAN_SCALE = 1000;
  localparam int NUM_W = 38;
  localparam int DEN_W = 21;
  localparam int N_W   = 20;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] pixel_in;
    logic [9:0] read_row;
    logic [9:0] read_col;
  } item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       inside_res;
  } result_t;

  // Maps an offset that may lie outside [0, n-1] back into the source range.
  function automatic logic signed [12:0] fold(input logic signed [12:0] d,
                                             input logic signed [12:0] n,
                                             input logic [2:0] how);
    logic signed [12:0] r;
    r = d;
    if (how == PAD_EDGE) begin
      if (d < 0) r = 13'sd0;
      else if (d >= n) r = n - 13'sd1;
    end else if (how == PAD_REFLECT) begin
      if (d < 0) r = -d;
      else if (d >= n) r = (n <<< 1) - 13'sd2 - d;
    end else begin
      if (d < 0) r = -d - 13'sd1;
      else if (d >= n) r = (n <<< 1) - 13'sd1 - d;
    end
    return r;
  endfunction

endpackage

### rtl/ibpe_ram.sv
module ibpe_ram
  import ibpe_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/image_border_padding_engine.sv
// Holds one source image and answers reads of it with a border added on every side.
// Raise start with an item while busy is low. Clear and unused items finish at once, as do
// loads under an invalid configuration or after the image is full; a load reads, then
// writes back the stored statistics, or only moves the position on a wrap past the last
// row. A read ends in S_RD_MAP on an invalid configuration or a coordinate outside the
// frame; in mean mode a border read also uses one restoring divider twice, one quotient
// bit per cycle (first the rounded mean scaled by 1000, then the division by 1000). A read
// result is presented on result for exactly one cycle with result_valid; the receiver
// cannot stall it, so it must take it in that cycle. Configuration is to be written through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block does not enforce it.
module image_border_padding_engine
  import ibpe_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_PAD  = DEF_MAX_PAD
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 item,
  output logic                  result_valid,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [12:0] MaxRowsL = 13'(MAX_ROWS);
  localparam logic [12:0] MaxColsL = 13'(MAX_COLS);
  localparam logic [12:0] MaxPadL  = 13'(MAX_PAD);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_LD_RD  = 8'b00000010,
    S_LD_WR  = 8'b00000100,
    S_RD_MAP = 8'b00001000,
    S_RD_MEM = 8'b00010000,
    S_RD_SEL = 8'b00100000,
    S_MUL    = 8'b01000000,
    S_DIV    = 8'b10000000
  } state_t;

  state_t state;

  logic [2:0] pad_mode;
  logic [9:0] image_height, image_width;
  logic [4:0] pad_size;
  logic [7:0] fill_value;

  logic [7:0]           image_max, image_min;
  logic [IMG_SUM_W-1:0] image_sum;
  logic [9:0]           load_row, load_col;

  logic [7:0] pix;
  logic [9:0] rd_row, rd_col;
  logic [9:0] eff_row, eff_col;
  logic [RW-1:0] fi;
  logic [CW-1:0] fj;
  logic [2:0] src;

  logic [IMG_SUM_W-1:0] mean_sum;
  logic [N_W-1:0]       mean_n;
  logic [NUM_W-1:0]     num;
  logic [DEN_W-1:0]     den, rem;
  logic [CNT_W-1:0]     cnt;
  logic                 pass;

  // Memories.
  logic          img_we, col_we, row_we;
  logic [AW-1:0] img_waddr, img_raddr;
  logic [7:0]    img_rdata;
  logic [CW-1:0] col_raddr;
  logic [RW-1:0] row_raddr;
  logic [STAT_W-1:0] col_rdata, row_rdata, col_wdata, row_wdata;

  ibpe_ram #(.WIDTH(8), .DEPTH(MAX_ROWS * MAX_COLS)) u_img (
    .clk(clk), .we(img_we), .waddr(img_waddr), .wdata(pix),
    .raddr(img_raddr), .rdata(img_rdata)
  );
  ibpe_ram #(.WIDTH(STAT_W), .DEPTH(MAX_COLS)) u_col (
    .clk(clk), .we(col_we), .waddr(CW'(eff_col)), .wdata(col_wdata),
    .raddr(col_raddr), .rdata(col_rdata)
  );
  ibpe_ram #(.WIDTH(STAT_W), .DEPTH(MAX_ROWS)) u_row (
    .clk(clk), .we(row_we), .waddr(RW'(eff_row)), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  logic cfg_ok;
  assign cfg_ok = (image_height >= 10'd2) && ({3'b0, image_height} <= MaxRowsL) &&
                  (image_width >= 10'd2) && ({3'b0, image_width} <= MaxColsL) &&
                  ({8'b0, pad_size} <= MaxPadL) &&
                  ({5'b0, pad_size} < image_height) && ({5'b0, pad_size} < image_width);

  assign busy = (state != S_IDLE);

  // Load position after the wrap at the current width.
  logic ld_wrap;
  always_comb begin
    ld_wrap = (load_col >= image_width);
    eff_col = ld_wrap ? 10'd0 : load_col;
    eff_row = ld_wrap ? load_row + 10'd1 : load_row;
  end

  // Statistic update for a load.
  logic [7:0] cmax, cmin, rmax, rmin;
  logic [COL_SUM_W-1:0] csum, rsum;
  always_comb begin
    {cmax, cmin, csum} = col_rdata;
    {rmax, rmin, rsum} = row_rdata;
    if (eff_row == 10'd0) begin
      col_wdata = {pix, pix, COL_SUM_W'(pix)};
    end else begin
      col_wdata = {(pix > cmax) ? pix : cmax, (pix < cmin) ? pix : cmin,
                   COL_SUM_W'(csum + COL_SUM_W'(pix))};
    end
    if (eff_col == 10'd0) begin
      row_wdata = {pix, pix, COL_SUM_W'(pix)};
    end else begin
      row_wdata = {(pix > rmax) ? pix : rmax, (pix < rmin) ? pix : rmin,
                   COL_SUM_W'(rsum + COL_SUM_W'(pix))};
    end
  end

  assign img_we    = (state == S_LD_WR);
  assign col_we    = img_we;
  assign row_we    = img_we;
  assign img_waddr = AW'(AW'(RW'(eff_row)) * AW'(MAX_COLS) + AW'(CW'(eff_col)));
  assign img_raddr = AW'(AW'(fi) * AW'(MAX_COLS) + AW'(fj));
  assign col_raddr = (state == S_LD_RD) ? CW'(eff_col) : fj;
  assign row_raddr = (state == S_LD_RD) ? RW'(eff_row) : fi;

  // Coordinate mapping for a read.
  logic signed [12:0] di, dj, hs, ws, foi, foj;
  logic rin, cin, in_frame;
  always_comb begin
    hs = $signed({3'b0, image_height});
    ws = $signed({3'b0, image_width});
    di = $signed({3'b0, rd_row}) - $signed({8'b0, pad_size});
    dj = $signed({3'b0, rd_col}) - $signed({8'b0, pad_size});
    rin = (di >= 0) && (di < hs);
    cin = (dj >= 0) && (dj < ws);
    in_frame = ({2'b0, rd_row} < {2'b0, image_height} + {6'b0, pad_size, 1'b0}) &&
               ({2'b0, rd_col} < {2'b0, image_width} + {6'b0, pad_size, 1'b0});
    foi = fold(di, hs, pad_mode);
    foj = fold(dj, ws, pad_mode);
  end

  // One restoring divider step.
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             ge;
  always_comb begin
    rem_sh = {rem, num[NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b0, den};
    ge     = !diff[DEN_W+1];
  end

  logic [7:0] stat_v;
  always_comb begin
    unique case (src)
      SRC_COL: stat_v = (pad_mode == PAD_MAXIMUM) ? col_rdata[STAT_W-1 -: 8] :
                                                   col_rdata[STAT_W-9 -: 8];
      SRC_ROW: stat_v = (pad_mode == PAD_MAXIMUM) ? row_rdata[STAT_W-1 -: 8] :
                                                   row_rdata[STAT_W-9 -: 8];
      SRC_ALL: stat_v = (pad_mode == PAD_MAXIMUM) ? image_max : image_min;
      default: stat_v = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pad_mode     <= PAD_CONSTANT;
      image_height <= 10'd2;
      image_width  <= 10'd2;
      pad_size     <= 5'd0;
      fill_value   <= 8'd0;
      image_max    <= 8'd0;
      image_min    <= 8'hFF;
      image_sum    <= '0;
      load_row     <= 10'd0;
      load_col     <= 10'd0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PAD_MODE:     pad_mode     <= cfg_data[2:0];
          REG_IMAGE_HEIGHT: image_height <= cfg_data;
          REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          REG_PAD_SIZE:     pad_size     <= cfg_data[4:0];
          REG_FILL_VALUE:   fill_value   <= cfg_data[7:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            pix    <= item.pixel_in;
            rd_row <= item.read_row;
            rd_col <= item.read_col;
            unique case (item.mode)
              MODE_CLEAR: begin
                image_max <= 8'd0;
                image_min <= 8'hFF;
                image_sum <= '0;
                load_row  <= 10'd0;
                load_col  <= 10'd0;
              end
              MODE_LOAD: begin
                if (cfg_ok && load_row < image_height) state <= S_LD_RD;
              end
              MODE_READ: state <= S_RD_MAP;
              default: ;
            endcase
          end
        end
        S_LD_RD: begin
          // A wrap that runs past the last row only moves the position.
          if (eff_row >= image_height) begin
            load_row <= eff_row;
            load_col <= 10'd0;
            state    <= S_IDLE;
          end else begin
            state <= S_LD_WR;
          end
        end
        S_LD_WR: begin
          if (pix > image_max) image_max <= pix;
          if (pix < image_min) image_min <= pix;
          image_sum <= IMG_SUM_W'(image_sum + IMG_SUM_W'(pix));
          if (eff_col + 10'd1 >= image_width) begin
            load_col <= 10'd0;
            load_row <= eff_row + 10'd1;
          end else begin
            load_col <= eff_col + 10'd1;
            load_row <= eff_row;
          end
          state <= S_IDLE;
        end
        S_RD_MAP: begin
          if (!cfg_ok || !in_frame) begin
            result       <= '{pixel_out: 8'd0, inside_res: 1'b0};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            fi    <= RW'(di);
            fj    <= CW'(dj);
            state <= S_RD_MEM;
            if (rin && cin) begin
              src <= SRC_IMAGE;
            end else if (pad_mode == PAD_CONSTANT) begin
              src <= SRC_FILL;
            end else if (pad_mode == PAD_EDGE || pad_mode == PAD_REFLECT ||
                         pad_mode == PAD_SYMMETRIC) begin
              src <= SRC_IMAGE;
              fi  <= RW'(foi);
              fj  <= CW'(foj);
            end else if (pad_mode == PAD_MAXIMUM || pad_mode == PAD_MINIMUM ||
                         pad_mode == PAD_MEAN) begin
              src <= cin ? SRC_COL : (rin ? SRC_ROW : SRC_ALL);
            end else begin
              src <= SRC_ZERO;
            end
          end
        end
        S_RD_MEM: state <= S_RD_SEL;
        S_RD_SEL: begin
          if (pad_mode == PAD_MEAN && (src == SRC_COL || src == SRC_ROW || src == SRC_ALL))
          begin
            priority case (src)
              SRC_COL: begin
                mean_sum <= IMG_SUM_W'(col_rdata[COL_SUM_W-1:0]);
                mean_n   <= N_W'(image_height);
              end
              SRC_ROW: begin
                mean_sum <= IMG_SUM_W'(row_rdata[COL_SUM_W-1:0]);
                mean_n   <= N_W'(image_width);
              end
              default: begin
                mean_sum <= image_sum;
                mean_n   <= N_W'(image_height) * N_W'(image_width);
              end
            endcase
            state <= S_MUL;
          end else begin
            priority case (src)
              SRC_IMAGE: result.pixel_out <= img_rdata;
              SRC_FILL:  result.pixel_out <= fill_value;
              default:   result.pixel_out <= stat_v;
            endcase
            result.inside_res <= 1'b1;
            result_valid      <= 1'b1;
            state             <= S_IDLE;
          end
        end
        S_MUL: begin
          num   <= NUM_W'(NUM_W'(mean_sum) * NUM_W'(2 * MEAN_SCALE) + NUM_W'(mean_n));
          den   <= {mean_n, 1'b0};
          rem   <= '0;
          cnt   <= '0;
          pass  <= 1'b0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
          num <= {num[NUM_W-2:0], ge};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NUM_W - 1)) begin
            cnt <= '0;
            rem <= '0;
            if (!pass) begin
              // Second pass: the rounded scaled mean divided by the scale.
              pass <= 1'b1;
              den  <= DEN_W'(MEAN_SCALE);
            end else begin
              result       <= '{pixel_out: {num[6:0], ge}, inside_res: 1'b1};
              result_valid <= 1'b1;
              state        <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  a_read_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.mode == MODE_READ) |=> busy && !result_valid)
    else $error("read accepted without entering the read sequence");

  a_no_result_other: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.mode != MODE_READ) |=> !result_valid)
    else $error("result produced for a clear or load");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (den != '0))
    else $error("divider running with a zero divisor");

endmodule
